// File: rtl/core/serial_command_pin_controller_core_assert.svh
// Assertion macros used by the serial command pin controller RTL.
`ifndef SERIAL_COMMAND_PIN_CONTROLLER_CORE_ASSERT_SVH
`define SERIAL_COMMAND_PIN_CONTROLLER_CORE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SCPC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a consequence holds in the cycle after its cause.
`define SCPC_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

// File: rtl/core/scpc_pkg.sv
// Types and constants of the serial command pin controller.
package scpc_pkg;

	localparam int LINE_LIMIT = 9;
	localparam int CNT_W = $clog2(LINE_LIMIT + 1);
	localparam int PERIOD_W = 16;
	localparam int PIN_N = 3;

	localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 16'd3000;
	localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 16'd200;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_SERVO  = 2'd1,
		MODE_MOTOR  = 2'd2,
		MODE_BUZZER = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REPLY_NONE    = 2'd0,
		REPLY_HIGH    = 2'd1,
		REPLY_LOW     = 2'd2,
		REPLY_STOPPED = 2'd3
	} reply_t;

	typedef enum logic [1:0] {
		PIN_A    = 2'd0,
		PIN_B    = 2'd1,
		PIN_C    = 2'd2,
		PIN_NONE = 2'd3
	} pin_sel_t;

	typedef enum logic {
		OP_CHAR = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic {
		REG_SLOW_PERIOD = 1'b0,
		REG_FAST_PERIOD = 1'b1
	} reg_idx_t;

	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [7:0] CHAR_CR = 8'd13;

	localparam logic [15:0] CMD_ST  = "ST";
	localparam logic [23:0] CMD_BT1 = "BT1";
	localparam logic [23:0] CMD_BT2 = "BT2";
	localparam logic [23:0] CMD_DC1 = "DC1";
	localparam logic [23:0] CMD_DC2 = "DC2";
	localparam logic [23:0] CMD_BZ1 = "BZ1";
	localparam logic [23:0] CMD_BZ2 = "BZ2";
	localparam logic [23:0] CMD_SV1 = "SV1";
	localparam logic [23:0] CMD_SV2 = "SV2";

	// Result word as it leaves the block.
	typedef struct packed {
		reply_t           reply;
		logic [PIN_N-1:0] enable;
		logic [PIN_N-1:0] drive;
	} result_t;

endpackage

// File: rtl/core/serial_command_pin_controller_core.sv
// Serial command pin controller: line parser, pin control and toggle timer.
//
// Usage: every input word on the s_ channel is either a received character
// (s_tuser = 0) or a one millisecond tick (s_tuser = 1). Characters build a
// command line; CR or LF ends a non-empty line, which is matched against
// ST, BT1, BT2, DC1, DC2, BZ1, BZ2, SV1 and SV2 by prefix. Ticks advance the
// toggle timer of the active pin. Every input word yields exactly one result
// word on the m_ channel with the pin levels, pin directions and a reply code.
// The cfg channel writes the slow period (index 0) and the fast period
// (index 1); it is always ready and should be used only while the block is
// idle.
// A word accepted on the s_ channel is captured in the input register, processed
// from there, and its result is then registered in the result register. The block
// takes one word per cycle while the receiver takes results; the input register
// and the result register form a two-stage pipeline.
// Reset clears all control state; the periods return to 3000 and 200 ticks.
// When the receiver holds m_tready low, the result register holds its word,
// the input register fills, and s_tready then drops until the result is taken.
`include "serial_command_pin_controller_core_assert.svh"

module serial_command_pin_controller_core
	import scpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,  // char_code[7:0], sense_a[8], sense_b[9], zero[15:10]
	input  logic                s_tuser,  // operation[0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // drive_a, drive_b, drive_c, enable_a, enable_b,
	                                      // enable_c, reply[7:6]
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [PERIOD_W-1:0] cfg_data
);

	// Input register.
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] char_s1;
	logic       sense_a_s1;
	logic       sense_b_s1;

	// Result register.
	logic    out_valid_q;
	result_t out_q;

	// Block state.
	logic [7:0]          prefix_q [3];
	logic [CNT_W-1:0]    count_q;
	mode_t               mode_q;
	pin_sel_t            sel_q;
	logic                toggle_q;
	logic [PERIOD_W-1:0] elapsed_q;
	logic [PIN_N-1:0]    levels_q;
	logic [PIN_N-1:0]    dirs_q;
	logic [PERIOD_W-1:0] slow_q;
	logic [PERIOD_W-1:0] fast_q;

	// Next-state values.
	logic [CNT_W-1:0]    count_d;
	mode_t               mode_d;
	pin_sel_t            sel_d;
	logic                toggle_d;
	logic [PERIOD_W-1:0] elapsed_d;
	logic [PIN_N-1:0]    levels_d;
	logic [PIN_N-1:0]    dirs_d;
	reply_t              reply_d;
	logic                prefix_we;

	logic                advance;
	logic                process;
	logic                is_term;
	logic                has2;
	logic                has3;
	logic [23:0]         line3;
	logic                start_req;
	mode_t               start_mode;
	pin_sel_t            start_pin;
	logic [PIN_N-1:0]    start_mask;
	logic [PERIOD_W-1:0] period;
	logic [PERIOD_W-1:0] elapsed_inc;

	assign advance   = !out_valid_q || m_tready;
	assign process   = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1      <= op_t'(s_tuser);
			char_s1    <= s_tdata[7:0];
			sense_a_s1 <= s_tdata[8];
			sense_b_s1 <= s_tdata[9];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q <= SLOW_PERIOD_RST;
			fast_q <= FAST_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SLOW_PERIOD: slow_q <= cfg_data;
				REG_FAST_PERIOD: fast_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_term = (char_s1 == CHAR_LF) || (char_s1 == CHAR_CR);
	assign has2    = count_q >= CNT_W'(2);
	assign has3    = count_q >= CNT_W'(3);
	assign line3   = {prefix_q[0], prefix_q[1], prefix_q[2]};

	// Command decode in match priority order.
	always_comb begin
		start_req  = 1'b1;
		start_mode = MODE_MOTOR;
		start_pin  = PIN_B;
		if (!has3) begin
			start_req = 1'b0;
		end else if (line3 == CMD_DC1) begin
			start_mode = MODE_MOTOR;
			start_pin  = PIN_B;
		end else if (line3 == CMD_DC2) begin
			start_mode = MODE_MOTOR;
			start_pin  = PIN_A;
		end else if (line3 == CMD_BZ1) begin
			start_mode = MODE_BUZZER;
			start_pin  = PIN_B;
		end else if (line3 == CMD_BZ2) begin
			start_mode = MODE_BUZZER;
			start_pin  = PIN_C;
		end else if (line3 == CMD_SV1) begin
			start_mode = MODE_SERVO;
			start_pin  = PIN_B;
		end else if (line3 == CMD_SV2) begin
			start_mode = MODE_SERVO;
			start_pin  = PIN_A;
		end else begin
			start_req = 1'b0;
		end
	end

	assign start_mask  = PIN_N'(3'b001 << start_pin);
	assign period      = (mode_q == MODE_SERVO) ? fast_q : slow_q;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + PERIOD_W'(1);

	always_comb begin
		count_d   = count_q;
		mode_d    = mode_q;
		sel_d     = sel_q;
		toggle_d  = toggle_q;
		elapsed_d = elapsed_q;
		levels_d  = levels_q;
		dirs_d    = dirs_q;
		reply_d   = REPLY_NONE;
		prefix_we = 1'b0;
		if (op_s1 == OP_TICK) begin
			if (mode_q != MODE_IDLE) begin
				// A period of zero acts like one because the count is at least one here.
				if (elapsed_inc >= period) begin
					toggle_d  = !toggle_q;
					elapsed_d = '0;
					case (sel_q)
						PIN_A:   levels_d[0] = !toggle_q;
						PIN_B:   levels_d[1] = !toggle_q;
						PIN_C:   levels_d[2] = !toggle_q;
						default: ;
					endcase
				end else begin
					elapsed_d = elapsed_inc;
				end
			end
		end else if (is_term) begin
			if (count_q != '0) begin
				count_d = '0;
				if (has2 && {prefix_q[0], prefix_q[1]} == CMD_ST) begin
					mode_d   = MODE_IDLE;
					levels_d = '0;
					reply_d  = REPLY_STOPPED;
				end else if (has3 && line3 == CMD_BT1) begin
					dirs_d[1] = 1'b0;
					reply_d   = sense_b_s1 ? REPLY_HIGH : REPLY_LOW;
				end else if (has3 && line3 == CMD_BT2) begin
					dirs_d[0] = 1'b0;
					reply_d   = sense_a_s1 ? REPLY_HIGH : REPLY_LOW;
				end else if (start_req) begin
					dirs_d    = dirs_q | start_mask;
					levels_d  = levels_q | start_mask;
					mode_d    = start_mode;
					sel_d     = start_pin;
					toggle_d  = 1'b1;
					elapsed_d = '0;
				end
			end
		end else if (count_q < CNT_W'(LINE_LIMIT)) begin
			prefix_we = !has3;
			count_d   = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			mode_q    <= MODE_IDLE;
			sel_q     <= PIN_A;
			toggle_q  <= 1'b0;
			elapsed_q <= '0;
			levels_q  <= '0;
			dirs_q    <= '0;
		end else if (process) begin
			count_q   <= count_d;
			mode_q    <= mode_d;
			sel_q     <= sel_d;
			toggle_q  <= toggle_d;
			elapsed_q <= elapsed_d;
			levels_q  <= levels_d;
			dirs_q    <= dirs_d;
		end
	end

	// Only the first three characters of a line are kept.
	always_ff @(posedge clk) begin
		if (process && prefix_we) begin
			prefix_q[count_q[1:0]] <= char_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			out_q.reply  <= reply_d;
			out_q.enable <= dirs_d;
			out_q.drive  <= levels_d;
		end
	end

	`SCPC_ASSERT_ALWAYS(a_sel_valid, sel_q != PIN_NONE, "active pin select is out of range")
	`SCPC_ASSERT_ALWAYS(a_count_limit, count_q <= CNT_W'(LINE_LIMIT),
		"line count exceeds the line limit")
	`SCPC_ASSERT_ALWAYS(a_stall_only, s_tready || (out_valid_q && !m_tready),
		"input stalled while the result register can move")
	`SCPC_ASSERT_NEXT(a_tick_no_reply, process && op_s1 == OP_TICK, out_q.reply == REPLY_NONE,
		"tick word produced a reply")
	`SCPC_ASSERT_ALWAYS(a_start_state,
		!(mode_q != $past(mode_q) && mode_q != MODE_IDLE) || (toggle_q && elapsed_q == '0),
		"mode started without a fresh toggle phase")

endmodule
